@@ design/elevation_cell_kalman_fusion_top_defines.svh @@
// Assertion macros shared by the elevation cell fusion checker.
`ifndef ELEVATION_CELL_KALMAN_FUSION_TOP_DEFINES_SVH
`define ELEVATION_CELL_KALMAN_FUSION_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ECKF_AST_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ECKF_AST_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/eckf_pkg.sv @@
// Types, constants and register defaults of the elevation cell fusion block.
`timescale 1ns / 1ps
package eckf_pkg;

    localparam int MAP_ROWS_DEF = 128;
    localparam int MAP_COLS_DEF = 128;

    localparam int RC_W  = 7;
    localparam int H_W   = 16;
    localparam int VAR_W = 20;
    localparam int ST_W  = 3;

    // Shared divider geometry: quotient bits, divisor and dividend widths.
    localparam int Q_W   = 20;
    localparam int DVS_W = 21;
    localparam int DVD_W = 40;

    localparam int FIFO_DEPTH = 2;

    localparam logic [ST_W-1:0] ST_IGNORED = 3'd0;
    localparam logic [ST_W-1:0] ST_FAR     = 3'd1;
    localparam logic [ST_W-1:0] ST_FIRST   = 3'd2;
    localparam logic [ST_W-1:0] ST_FUSED   = 3'd3;
    localparam logic [ST_W-1:0] ST_OUTLIER = 3'd4;

    localparam logic [1:0] K_IGN  = 2'd0;
    localparam logic [1:0] K_FAR  = 2'd1;
    localparam logic [1:0] K_NEAR = 2'd2;

    localparam int CFG_AW = 5;
    localparam logic [2:0] REG_MAX_RANGE_SQ   = 3'd0;
    localparam logic [2:0] REG_MEAS_BASE      = 3'd1;
    localparam logic [2:0] REG_RANGE_VAR_COEF = 3'd2;
    localparam logic [2:0] REG_GATE_SIGMA_SQ  = 3'd3;
    localparam logic [2:0] REG_VAR_MIN        = 3'd4;

    localparam logic [30:0] RST_MAX_RANGE_SQ   = 31'd37748736;
    localparam logic [19:0] RST_MEAS_BASE      = 20'd944;
    localparam logic [15:0] RST_RANGE_VAR_COEF = 16'd41;
    localparam logic [11:0] RST_GATE_SIGMA_SQ  = 12'd144;
    localparam logic [19:0] RST_VAR_MIN        = 20'd944;

    typedef struct packed {
        logic                   point_ok;
        logic [RC_W-1:0]        cell_row;
        logic [RC_W-1:0]        cell_col;
        logic signed [H_W-1:0]  offset_x;
        logic signed [H_W-1:0]  offset_y;
        logic signed [H_W-1:0]  height;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0]        status;
        logic                   cell_known;
        logic signed [H_W-1:0]  cell_height;
        logic [VAR_W-1:0]       cell_variance;
    } t_out_item;

    typedef struct packed {
        logic [30:0]      max_range_sq;
        logic [VAR_W-1:0] meas_base;
        logic [15:0]      range_var_coef;
        logic [11:0]      gate_sigma_sq;
        logic [VAR_W-1:0] var_min;
    } t_cfg;

    typedef struct packed {
        logic [1:0]             kind;
        logic [RC_W-1:0]        cell_row;
        logic [RC_W-1:0]        cell_col;
        logic signed [H_W-1:0]  height;
        logic [VAR_W-1:0]       meas;
    } t_job;

endpackage

@@ design/elevation_cell_kalman_fusion_top.sv @@
// Each input item ends as an ignored, far, first-observation, outlier or fused result; a fuse
// with a nonzero variance sum runs two 20-step divisions through the shared radix-2 divider.
// The front takes a new item only after it has pushed its previous job into the queue.
// Reset is synchronous and active low; the cell memory is then cleared one cell per cycle,
// all MAP_ROWS*MAP_COLS cells (16384 by default), and configuration returns to defaults.
`timescale 1ns / 1ps
module elevation_cell_kalman_fusion_top #(
    parameter int MAP_ROWS = eckf_pkg::MAP_ROWS_DEF,
    parameter int MAP_COLS = eckf_pkg::MAP_COLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  eckf_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output eckf_pkg::t_out_item         o_out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [eckf_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import eckf_pkg::*;

    // The block is split into a front that classifies each item and computes
    // its measurement variance, a two-entry job queue, and a back that owns
    // the cell memory and performs the gated Kalman update. The queue lets
    // the front take the next item while the back is still dividing.

    t_cfg       r_cfg;
    logic [2:0] w_reg;
    logic       w_wr;
    logic       w_hold;
    logic       w_push;
    logic       w_full;
    logic       w_pop;
    logic       w_empty;
    t_job       w_job_in;
    t_job       w_job_out;

    // Registers sit at word addresses; the low two address bits are ignored.
    assign w_reg  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_range_sq   <= RST_MAX_RANGE_SQ;
            r_cfg.meas_base      <= RST_MEAS_BASE;
            r_cfg.range_var_coef <= RST_RANGE_VAR_COEF;
            r_cfg.gate_sigma_sq  <= RST_GATE_SIGMA_SQ;
            r_cfg.var_min        <= RST_VAR_MIN;
        end else if (w_wr) begin
            case (w_reg)
                REG_MAX_RANGE_SQ:   r_cfg.max_range_sq   <= pwdata[30:0];
                REG_MEAS_BASE:      r_cfg.meas_base      <= pwdata[VAR_W-1:0];
                REG_RANGE_VAR_COEF: r_cfg.range_var_coef <= pwdata[15:0];
                REG_GATE_SIGMA_SQ:  r_cfg.gate_sigma_sq  <= pwdata[11:0];
                REG_VAR_MIN:        r_cfg.var_min        <= pwdata[VAR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_MAX_RANGE_SQ:   prdata = {1'b0, r_cfg.max_range_sq};
            REG_MEAS_BASE:      prdata = {12'd0, r_cfg.meas_base};
            REG_RANGE_VAR_COEF: prdata = {16'd0, r_cfg.range_var_coef};
            REG_GATE_SIGMA_SQ:  prdata = {20'd0, r_cfg.gate_sigma_sq};
            REG_VAR_MIN:        prdata = {12'd0, r_cfg.var_min};
            default:            prdata = '0;
        endcase
    end

    // The front stays closed while the back sweeps the cell memory.
    eckf_front #(
        .MAP_ROWS (MAP_ROWS),
        .MAP_COLS (MAP_COLS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_hold     (w_hold),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_push     (w_push),
        .o_job      (w_job_in),
        .i_full     (w_full)
    );

    eckf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_job_out)
    );

    // The back holds its result in an output register, so a stalled
    // consumer only stops the back; the queue keeps the front moving.
    eckf_back #(
        .MAP_ROWS (MAP_ROWS),
        .MAP_COLS (MAP_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (w_empty),
        .i_job       (w_job_out),
        .o_pop       (w_pop),
        .o_clearing  (w_hold),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

@@ design/eckf_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module eckf_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [eckf_pkg::DVD_W-1:0] i_dividend,
    input  logic [eckf_pkg::DVS_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [eckf_pkg::Q_W-1:0]  o_quot
);
    import eckf_pkg::*;

    localparam int CW = $clog2(Q_W);

    logic [DVS_W-1:0] r_rem;
    logic [Q_W-1:0]   r_lo;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W+1:0] w_diff;

    // The caller guarantees the quotient fits Q_W bits, so the upper
    // dividend part is already below the divisor.
    assign w_diff = {1'b0, r_rem, r_lo[Q_W-1]} - {2'b00, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend[DVD_W-1:Q_W]};
            r_lo  <= i_dividend[Q_W-1:0];
        end else if (r_busy) begin
            if (!w_diff[DVS_W+1]) begin
                r_rem <= w_diff[DVS_W-1:0];
                r_lo  <= {r_lo[Q_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DVS_W-2:0], r_lo[Q_W-1]};
                r_lo  <= {r_lo[Q_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_lo;

endmodule

@@ design/eckf_fifo.sv @@
// Short job queue between the classifying front and the update back.
`timescale 1ns / 1ps
module eckf_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  eckf_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output eckf_pkg::t_job o_job
);
    import eckf_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    t_job          r_q [FIFO_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_job;
        end
    end

endmodule

@@ design/eckf_front.sv @@
// Front end: takes points, checks validity and range, derives measurement variance.
`timescale 1ns / 1ps
module eckf_front #(
    parameter int MAP_ROWS = eckf_pkg::MAP_ROWS_DEF,
    parameter int MAP_COLS = eckf_pkg::MAP_COLS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  eckf_pkg::t_cfg     i_cfg,
    input  logic               i_hold,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  eckf_pkg::t_in_item i_in_item,
    output logic               o_push,
    output eckf_pkg::t_job     o_job,
    input  logic               i_full
);
    import eckf_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SQ   = 2'd1;
    localparam logic [1:0] F_MUL  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    t_in_item           r_item;
    logic               r_ign;
    logic [30:0]        r_sqx;
    logic [30:0]        r_sqy;
    logic               r_far;
    logic [47:0]        r_prod;
    logic signed [31:0] w_sqx;
    logic signed [31:0] w_sqy;
    logic [31:0]        w_r2;
    logic [32:0]        w_msum;
    logic [VAR_W-1:0]   w_meas;
    logic               w_ign;

    assign o_in_ready = (r_state == F_IDLE) && !i_hold;

    assign w_ign = !i_in_item.point_ok
                || (int'(i_in_item.cell_row) >= MAP_ROWS)
                || (int'(i_in_item.cell_col) >= MAP_COLS);

    assign w_sqx = r_item.offset_x * r_item.offset_x;
    assign w_sqy = r_item.offset_y * r_item.offset_y;
    assign w_r2  = {1'b0, r_sqx} + {1'b0, r_sqy};

    // Measurement variance saturates at the top of the 20-bit range.
    assign w_msum = {13'd0, i_cfg.meas_base} + {1'b0, r_prod[47:16]};
    assign w_meas = (w_msum[32:VAR_W] != '0) ? '1 : w_msum[VAR_W-1:0];

    assign o_push          = (r_state == F_PUSH) && !i_full;
    assign o_job.kind      = r_ign ? K_IGN : (r_far ? K_FAR : K_NEAR);
    assign o_job.cell_row  = r_item.cell_row;
    assign o_job.cell_col  = r_item.cell_col;
    assign o_job.height    = r_item.height;
    assign o_job.meas      = w_meas;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_state = F_SQ;
                end
            end
            F_SQ:   n_state = F_MUL;
            F_MUL:  n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_in_valid && o_in_ready) begin
            r_item <= i_in_item;
            r_ign  <= w_ign;
        end
        if (r_state == F_SQ) begin
            r_sqx <= w_sqx[30:0];
            r_sqy <= w_sqy[30:0];
        end
        if (r_state == F_MUL) begin
            r_far  <= w_r2 > {1'b0, i_cfg.max_range_sq};
            r_prod <= i_cfg.range_var_coef * w_r2;
        end
    end

endmodule

@@ design/eckf_back.sv @@
// Back end: cell memory, outlier gate and Kalman update with a shared divider.
`timescale 1ns / 1ps
module eckf_back #(
    parameter int MAP_ROWS = eckf_pkg::MAP_ROWS_DEF,
    parameter int MAP_COLS = eckf_pkg::MAP_COLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  eckf_pkg::t_cfg      i_cfg,
    input  logic                i_empty,
    input  eckf_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_clearing,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output eckf_pkg::t_out_item o_out_item
);
    import eckf_pkg::*;

    localparam int DEPTH = MAP_ROWS * MAP_COLS;
    localparam int IW    = $clog2(DEPTH);
    localparam int MW    = 1 + H_W + VAR_W;

    localparam logic [2:0] B_CLR  = 3'd0;
    localparam logic [2:0] B_IDLE = 3'd1;
    localparam logic [2:0] B_EVAL = 3'd2;
    localparam logic [2:0] B_MUL  = 3'd3;
    localparam logic [2:0] B_GATE = 3'd4;
    localparam logic [2:0] B_DIV1 = 3'd5;
    localparam logic [2:0] B_DIV2 = 3'd6;

    logic [MW-1:0]          r_mem [DEPTH];
    logic [MW-1:0]          r_rd;
    logic [2:0]             r_state;
    logic [2:0]             n_state;
    logic [IW-1:0]          r_clr_addr;
    t_job                   r_job;
    logic [IW-1:0]          r_idx;
    logic signed [H_W-1:0]  r_h;
    logic [VAR_W-1:0]       r_v;
    logic signed [H_W:0]    r_inn;
    logic [DVS_W-1:0]       r_s;
    logic [31:0]            r_sq;
    logic [32:0]            r_gs;
    logic [35:0]            r_p1;
    logic [39:0]            r_p2;
    logic [Q_W-1:0]         r_q1;
    logic                   r_out_valid;
    logic                   n_out_valid;
    t_out_item              r_out;
    t_out_item              n_out;

    logic [IW-1:0]          w_idx;
    logic                   w_rd_valid;
    logic signed [H_W-1:0]  w_rd_h;
    logic [VAR_W-1:0]       w_rd_v;
    logic                   w_we;
    logic [IW-1:0]          w_waddr;
    logic [MW-1:0]          w_wdata;
    logic                   w_start;
    logic [DVD_W-1:0]       w_dividend;
    logic                   w_done;
    logic [Q_W-1:0]         w_quot;
    logic [H_W-1:0]         w_abs;
    logic signed [2*H_W+1:0] w_sq;
    logic                   w_outlier;
    logic [17:0]            w_qmag;
    logic [17:0]            w_qs;
    logic [17:0]            w_hsum;
    logic [VAR_W-1:0]       w_vnew;

    assign w_idx = IW'(i_job.cell_row) * IW'(MAP_COLS) + IW'(i_job.cell_col);
    assign {w_rd_valid, w_rd_h, w_rd_v} = r_rd;

    assign o_pop       = (r_state == B_IDLE) && !i_empty && !r_out_valid;
    assign o_clearing  = (r_state == B_CLR);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Magnitude of the innovation; it never exceeds 16 bits.
    assign w_abs = r_inn[H_W] ? H_W'(-r_inn) : r_inn[H_W-1:0];
    assign w_sq  = r_inn * r_inn;
    assign w_outlier = {r_sq, 4'b0000} > {3'b000, r_gs};

    // Height step: the quotient magnitude is bounded by the innovation.
    assign w_qmag = r_q1[17:0];
    assign w_qs   = r_inn[H_W] ? (18'd0 - w_qmag) : w_qmag;
    assign w_hsum = {{2{r_h[H_W-1]}}, r_h} + w_qs;
    assign w_vnew = (w_quot < i_cfg.var_min) ? i_cfg.var_min : w_quot;

    eckf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_s),
        .o_done     (w_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = '0;
        w_start     = 1'b0;
        w_dividend  = {4'd0, r_p1};
        case (r_state)
            B_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                if (r_clr_addr == IW'(DEPTH - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (o_pop) begin
                    if (i_job.kind == K_IGN) begin
                        n_out_valid = 1'b1;
                        n_out       = '{ST_IGNORED, 1'b0, '0, '0};
                    end else begin
                        n_state = B_EVAL;
                    end
                end
            end
            B_EVAL: begin
                if (r_job.kind == K_FAR) begin
                    n_out_valid = 1'b1;
                    n_out = '{ST_FAR, w_rd_valid,
                              w_rd_valid ? w_rd_h : '0,
                              w_rd_valid ? w_rd_v : '0};
                    n_state = B_IDLE;
                end else if (!w_rd_valid) begin
                    w_we        = 1'b1;
                    w_wdata     = {1'b1, r_job.height, r_job.meas};
                    n_out_valid = 1'b1;
                    n_out       = '{ST_FIRST, 1'b1, r_job.height, r_job.meas};
                    n_state     = B_IDLE;
                end else begin
                    n_state = B_MUL;
                end
            end
            B_MUL: n_state = B_GATE;
            B_GATE: begin
                if (w_outlier) begin
                    n_out_valid = 1'b1;
                    n_out       = '{ST_OUTLIER, 1'b1, r_h, r_v};
                    n_state     = B_IDLE;
                end else if (r_s == '0) begin
                    w_we        = 1'b1;
                    w_wdata     = {1'b1, r_h, i_cfg.var_min};
                    n_out_valid = 1'b1;
                    n_out       = '{ST_FUSED, 1'b1, r_h, i_cfg.var_min};
                    n_state     = B_IDLE;
                end else begin
                    w_start = 1'b1;
                    n_state = B_DIV1;
                end
            end
            B_DIV1: begin
                if (w_done) begin
                    w_start    = 1'b1;
                    w_dividend = r_p2;
                    n_state    = B_DIV2;
                end
            end
            B_DIV2: begin
                if (w_done) begin
                    w_we        = 1'b1;
                    w_wdata     = {1'b1, w_hsum[H_W-1:0], w_vnew};
                    n_out_valid = 1'b1;
                    n_out       = '{ST_FUSED, 1'b1, w_hsum[H_W-1:0], w_vnew};
                    n_state     = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == B_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (o_pop) begin
            r_job <= i_job;
            r_idx <= w_idx;
        end
        if (r_state == B_EVAL) begin
            r_h   <= w_rd_h;
            r_v   <= w_rd_v;
            r_inn <= (H_W+1)'(r_job.height) - (H_W+1)'(w_rd_h);
            r_s   <= {1'b0, w_rd_v} + {1'b0, r_job.meas};
        end
        if (r_state == B_MUL) begin
            r_sq <= w_sq[31:0];
            r_gs <= i_cfg.gate_sigma_sq * r_s;
            r_p1 <= r_v * w_abs;
            r_p2 <= r_v * r_job.meas;
        end
        if (r_state == B_DIV1 && w_done) begin
            r_q1 <= w_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (o_pop) begin
            r_rd <= r_mem[w_idx];
        end
    end

endmodule

@@ design/eckf_checker.sv @@
// Port-level checker for the elevation cell fusion block and its bind.
`timescale 1ns / 1ps
`include "elevation_cell_kalman_fusion_top_defines.svh"
module eckf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input eckf_pkg::t_out_item o_out_item
);
    import eckf_pkg::*;

    `ECKF_AST_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")
    `ECKF_AST_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_item), "result changed while stalled")
    `ECKF_AST_IMP(a_status_range, i_clk, i_rst_n, o_out_valid, o_out_item.status <= ST_OUTLIER, "status code out of range")
    `ECKF_AST_IMP(a_unknown_zero, i_clk, i_rst_n, o_out_valid && !o_out_item.cell_known, (o_out_item.cell_height == '0) && (o_out_item.cell_variance == '0), "unknown cell reports nonzero estimate")
    `ECKF_AST_IMP(a_update_known, i_clk, i_rst_n, o_out_valid && ((o_out_item.status == ST_FIRST) || (o_out_item.status == ST_FUSED) || (o_out_item.status == ST_OUTLIER)), o_out_item.cell_known, "updated or gated cell not known")

endmodule

bind elevation_cell_kalman_fusion_top eckf_checker u_eckf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
